>>> hdl/spg_pkg.sv
// Package for the servo pulse generator: register indexes, config and result types.
// No dependencies; used by every module under hdl/.
package spg_pkg;

    localparam int TickW  = 11;
    localparam int PulseW = 8;
    localparam int CntW   = 8;
    localparam int StepW  = 4;
    localparam int CfgIdxW  = 3;
    localparam int CfgDataW = 11;
    localparam int SDataW = 8;
    localparam int MDataW = 24;

    localparam logic [PulseW-1:0] PulseReset = PulseW'(100);

    typedef enum logic [CfgIdxW-1:0] {
        REG_MIN_PULSE    = 3'd0,
        REG_MAX_PULSE    = 3'd1,
        REG_FRAME_LEN    = 3'd2,
        REG_STORED_PULSE = 3'd3,
        REG_DEBOUNCE     = 3'd4,
        REG_SAVE_DELAY   = 3'd5,
        REG_RAMP_FRAMES  = 3'd6,
        REG_STEP_SIZE    = 3'd7
    } cfg_reg_t;

    typedef struct packed {
        logic [PulseW-1:0] min_pulse;
        logic [PulseW-1:0] max_pulse;
        logic [TickW-1:0]  frame_len;
        logic [PulseW-1:0] stored_pulse;
        logic [CntW-1:0]   debounce_frames;
        logic [CntW-1:0]   save_delay_frames;
        logic [CntW-1:0]   ramp_frames;
        logic [StepW-1:0]  step_size;
    } spg_cfg_t;

    typedef struct packed {
        logic              servo_out;
        logic [PulseW-1:0] current_pulse;
        logic              save_request;
        logic [PulseW-1:0] save_value;
    } spg_result_t;

endpackage

>>> hdl/servo_pulse_generator_with_buttons.sv
// Top level of the servo pulse generator with two debounced adjust buttons.
// Depends on spg_pkg, spg_cfg and spg_core.
//
// One input item is one timing tick carrying the raw active-low button levels;
// every item gives exactly one result item with the servo level, the width in
// use and a one-tick save request. Items pass an input register and a result
// register; one item is taken per clock as long as the result side keeps up.
// Configuration writes are taken at any time with cfg_ready tied high, but
// should be made only while no item is in flight.
module servo_pulse_generator_with_buttons (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [spg_pkg::SDataW-1:0]   s_tdata,  // inc_released, dec_released, zero pad
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [spg_pkg::MDataW-1:0]   m_tdata,  // servo_out, current_pulse[7:0],
                                                   // save_request, save_value[7:0], zero pad
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [spg_pkg::CfgIdxW-1:0]  cfg_index,
    input  logic [spg_pkg::CfgDataW-1:0] cfg_data
);
    import spg_pkg::*;

    spg_cfg_t    cfg;
    spg_result_t result;

    logic        in_vld_reg;
    logic        inc_reg, dec_reg;
    logic        out_vld_reg;
    spg_result_t out_reg;
    logic        advance;

    assign advance  = !out_vld_reg || m_tready;
    assign s_tready = !in_vld_reg || advance;
    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {{(MDataW-$bits(spg_result_t)){1'b0}},
                       out_reg.save_value, out_reg.save_request,
                       out_reg.current_pulse, out_reg.servo_out};

    spg_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    spg_core u_core (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .step         (in_vld_reg && advance),
        .inc_released (inc_reg),
        .dec_released (dec_reg),
        .cfg          (cfg),
        .result       (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end else begin
            if (s_tready) begin
                in_vld_reg <= s_tvalid;
            end
            if (advance) begin
                out_vld_reg <= in_vld_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            inc_reg <= s_tdata[0];
            dec_reg <= s_tdata[1];
        end
        if (advance && in_vld_reg) begin
            out_reg <= result;
        end
    end

endmodule

>>> hdl/spg_cfg.sv
// Configuration register bank of the servo pulse generator.
// Depends on spg_pkg.
module spg_cfg (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [spg_pkg::CfgIdxW-1:0]  cfg_index,
    input  logic [spg_pkg::CfgDataW-1:0] cfg_data,
    output spg_pkg::spg_cfg_t            cfg
);
    import spg_pkg::*;

    spg_cfg_t cfg_reg, cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_reg_t'(cfg_index))
                REG_MIN_PULSE:    cfg_next.min_pulse         = cfg_data[PulseW-1:0];
                REG_MAX_PULSE:    cfg_next.max_pulse         = cfg_data[PulseW-1:0];
                REG_FRAME_LEN:    cfg_next.frame_len         = cfg_data[TickW-1:0];
                REG_STORED_PULSE: cfg_next.stored_pulse      = cfg_data[PulseW-1:0];
                REG_DEBOUNCE:     cfg_next.debounce_frames   = cfg_data[CntW-1:0];
                REG_SAVE_DELAY:   cfg_next.save_delay_frames = cfg_data[CntW-1:0];
                REG_RAMP_FRAMES:  cfg_next.ramp_frames       = cfg_data[CntW-1:0];
                REG_STEP_SIZE:    cfg_next.step_size         = cfg_data[StepW-1:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.min_pulse         <= PulseW'(100);
            cfg_reg.max_pulse         <= PulseW'(200);
            cfg_reg.frame_len         <= TickW'(2000);
            cfg_reg.stored_pulse      <= PulseW'(100);
            cfg_reg.debounce_frames   <= CntW'(5);
            cfg_reg.save_delay_frames <= CntW'(150);
            cfg_reg.ramp_frames       <= CntW'(2);
            cfg_reg.step_size         <= StepW'(2);
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

>>> hdl/spg_core.sv
// Per-tick state and update logic: frame counter, start-up ramp, button debounce, save timer.
// Depends on spg_pkg.
module spg_core (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  step,
    input  logic                  inc_released,
    input  logic                  dec_released,
    input  spg_pkg::spg_cfg_t     cfg,
    output spg_pkg::spg_result_t  result
);
    import spg_pkg::*;

    logic [TickW-1:0]  tick_reg, tick_next;
    logic [PulseW-1:0] pw_reg, pw_next;
    logic              ramping_reg, ramping_next;
    logic [CntW-1:0]   ramp_cnt_reg, ramp_cnt_next;
    logic              inc_lvl_reg, inc_lvl_next, dec_lvl_reg, dec_lvl_next;
    logic [CntW-1:0]   inc_age_reg, inc_age_next, dec_age_reg, dec_age_next;
    logic              inc_done_reg, inc_done_next, dec_done_reg, dec_done_next;
    logic              save_pend_reg, save_pend_next;
    logic [CntW-1:0]   save_age_reg, save_age_next;

    logic              frame_end;
    logic [PulseW-1:0] target;
    logic [PulseW:0]   inc_sum;
    logic [PulseW-1:0] dec_diff;
    logic              req;

    function automatic logic [CntW-1:0] sat_inc(input logic [CntW-1:0] v);
        return (v == '1) ? v : v + CntW'(1);
    endfunction

    always_comb begin
        frame_end      = (tick_reg >= cfg.frame_len);
        ramping_next   = ramping_reg;
        inc_lvl_next   = inc_lvl_reg;
        dec_lvl_next   = dec_lvl_reg;
        inc_done_next  = inc_done_reg;
        dec_done_next  = dec_done_reg;
        save_pend_next = save_pend_reg;
        pw_next        = pw_reg;
        req            = 1'b0;

        inc_age_next  = frame_end ? sat_inc(inc_age_reg)  : inc_age_reg;
        dec_age_next  = frame_end ? sat_inc(dec_age_reg)  : dec_age_reg;
        save_age_next = frame_end ? sat_inc(save_age_reg) : save_age_reg;
        ramp_cnt_next = frame_end ? sat_inc(ramp_cnt_reg) : ramp_cnt_reg;
        tick_next     = (frame_end ? '0 : tick_reg) + TickW'(1);

        target = (cfg.stored_pulse < cfg.min_pulse || cfg.stored_pulse > cfg.max_pulse)
                 ? cfg.min_pulse : cfg.stored_pulse;
        inc_sum  = {1'b0, pw_reg} + {{(PulseW+1-StepW){1'b0}}, cfg.step_size};
        dec_diff = (pw_reg >= {{(PulseW-StepW){1'b0}}, cfg.step_size})
                   ? pw_reg - {{(PulseW-StepW){1'b0}}, cfg.step_size} : '0;

        if (ramping_reg) begin
            if (frame_end && ramp_cnt_next >= cfg.ramp_frames) begin
                ramp_cnt_next = '0;
                if (pw_reg < target) begin
                    pw_next = pw_reg + PulseW'(1);
                end
            end
            if (pw_next >= target) begin
                ramping_next = 1'b0;
            end
        end else begin
            if (inc_released != inc_lvl_reg) begin
                inc_lvl_next = inc_released;
                inc_age_next = '0;
                if (inc_released) begin
                    inc_done_next = 1'b0;
                end
            end
            if (dec_released != dec_lvl_reg) begin
                dec_lvl_next = dec_released;
                dec_age_next = '0;
                if (dec_released) begin
                    dec_done_next = 1'b0;
                end
            end
            if (!inc_lvl_next && !inc_done_next && inc_age_next >= cfg.debounce_frames) begin
                inc_done_next  = 1'b1;
                pw_next        = (inc_sum > {1'b0, cfg.max_pulse})
                                 ? cfg.max_pulse : inc_sum[PulseW-1:0];
                save_pend_next = 1'b1;
                save_age_next  = '0;
            end else if (!dec_lvl_next && !dec_done_next
                         && dec_age_next >= cfg.debounce_frames) begin
                dec_done_next  = 1'b1;
                pw_next        = (dec_diff < cfg.min_pulse) ? cfg.min_pulse : dec_diff;
                save_pend_next = 1'b1;
                save_age_next  = '0;
            end
            if (save_pend_next && save_age_next >= cfg.save_delay_frames) begin
                save_pend_next = 1'b0;
                req            = 1'b1;
            end
        end

        result.servo_out     = (tick_next <= {{(TickW-PulseW){1'b0}}, pw_next});
        result.current_pulse = pw_next;
        result.save_request  = req;
        result.save_value    = req ? pw_next : '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tick_reg      <= '0;
            pw_reg        <= PulseReset;
            ramping_reg   <= 1'b1;
            ramp_cnt_reg  <= '0;
            inc_lvl_reg   <= 1'b1;
            dec_lvl_reg   <= 1'b1;
            inc_age_reg   <= '0;
            dec_age_reg   <= '0;
            inc_done_reg  <= 1'b0;
            dec_done_reg  <= 1'b0;
            save_pend_reg <= 1'b0;
            save_age_reg  <= '0;
        end else if (step) begin
            tick_reg      <= tick_next;
            pw_reg        <= pw_next;
            ramping_reg   <= ramping_next;
            ramp_cnt_reg  <= ramp_cnt_next;
            inc_lvl_reg   <= inc_lvl_next;
            dec_lvl_reg   <= dec_lvl_next;
            inc_age_reg   <= inc_age_next;
            dec_age_reg   <= dec_age_next;
            inc_done_reg  <= inc_done_next;
            dec_done_reg  <= dec_done_next;
            save_pend_reg <= save_pend_next;
            save_age_reg  <= save_age_next;
        end
    end

endmodule
